>>> src/generational_handle_allocator_assert.svh
// Assertion helpers for the handle allocator, clocked on clk_i, off during reset.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

`define GHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define GHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  `GHA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> src/gha_pkg.sv
package gha_pkg;

  localparam int SLOT_COUNT_DEF = 1024;
  localparam int GEN_BITS_DEF   = 8;

  localparam int MODE_W   = 2;
  localparam int IDX_W    = 10;
  localparam int GEN_W    = 8;
  localparam int CFG_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } gha_fifo_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } gha_state_e;

endpackage

>>> src/gha_slot_mem.sv
module gha_slot_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 9
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/gha_free_fifo.sv
module gha_free_fifo import gha_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 18
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gha_fifo_ctrl_t             ctrl_i,
  input  logic [DATA_W-1:0]          push_data_i,
  input  logic                       head_rd_i,
  output logic [DATA_W-1:0]          head_data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] head_data_q;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign do_push = ctrl_i.push && (count_q != CNT_FULL);
  assign do_pop  = ctrl_i.pop && (count_q != '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_pop) begin
      head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
      count_d = count_d - 1'b1;
    end
    if (do_push) begin
      tail_d  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
      count_d = count_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_rd_i) begin
      head_data_q <= mem[head_q];
    end
  end

  assign head_data_o = head_data_q;
  assign count_o     = count_q;

endmodule

>>> src/generational_handle_allocator.sv
// Generational handle allocator. Each request beat (create, remove, query) returns one
// result beat. A request is taken in the idle state, reading the slot memory and the
// free-slot queue head, and resolved in the execute state once the output is free, which
// writes back and loads the output register. No request is taken in the meantime. A new
// request is taken while an earlier result still waits at the output. Created slots reuse
// the oldest freed slot (generation plus one) once more than cfg_q freed slots wait, else
// take a fresh slot at generation zero, or report full. No clearing pass after reset.
`include "generational_handle_allocator_assert.svh"

module generational_handle_allocator import gha_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int GEN_BITS   = GEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [IDX_W-1:0]    handle_index_i,
  input  logic [GEN_W-1:0]    handle_generation_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    out_index_o,
  output logic [GEN_W-1:0]    out_generation_o,
  output logic                alive_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  localparam int SIDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_W = GEN_BITS + 1;
  localparam int ENT_W  = SIDX_W + GEN_BITS;

  gha_state_e state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [MODE_W-1:0] mode_q;
  logic [IDX_W-1:0]  idx_q;
  logic [GEN_W-1:0]  gen_q;
  logic [CNT_W-1:0]  mark_q, mark_d;

  logic              out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]  oidx_q, oidx_d;
  logic [GEN_W-1:0]  ogen_q, ogen_d;
  logic              alive_q, alive_d;

  logic              acc, done;
  logic [SLOT_W-1:0] slot_rd, slot_wr;
  logic [SIDX_W-1:0] slot_waddr, slot_idx;
  logic              slot_we;
  logic [GEN_BITS-1:0] slot_gen, new_gen;
  logic              slot_valid, hit;
  gha_fifo_ctrl_t    fifo_ctrl;
  logic [ENT_W-1:0]  head_ent;
  logic [CNT_W-1:0]  free_cnt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign done       = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

  gha_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .DATA_W (SLOT_W)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (SIDX_W'(handle_index_i)),
    .rd_data_o (slot_rd),
    .wr_en_i   (slot_we),
    .wr_addr_i (slot_waddr),
    .wr_data_i (slot_wr)
  );

  gha_free_fifo #(
    .DEPTH  (SLOT_COUNT),
    .DATA_W (ENT_W)
  ) u_free_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fifo_ctrl),
    .push_data_i ({slot_idx, slot_gen}),
    .head_rd_i   (acc),
    .head_data_o (head_ent),
    .count_o     (free_cnt)
  );

  assign slot_valid = slot_rd[GEN_BITS];
  assign slot_gen   = slot_rd[GEN_BITS-1:0];
  assign slot_idx   = SIDX_W'(idx_q);
  assign hit        = (32'(idx_q) < 32'(mark_q)) && slot_valid
                      && (32'(gen_q) == 32'(slot_gen));
  assign new_gen    = head_ent[GEN_BITS-1:0] + 1'b1;

  always_comb begin
    state_d        = state_q;
    mark_d         = mark_q;
    status_d       = STATUS_OK;
    oidx_d         = '0;
    ogen_d         = '0;
    alive_d        = 1'b0;
    slot_we        = 1'b0;
    slot_waddr     = slot_idx;
    slot_wr        = {1'b0, slot_gen};
    fifo_ctrl.push = 1'b0;
    fifo_ctrl.pop  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (mode_q)
          MODE_CREATE: begin
            if (32'(free_cnt) > 32'(cfg_q)) begin
              slot_waddr    = head_ent[ENT_W-1:GEN_BITS];
              slot_wr       = {1'b1, new_gen};
              slot_we       = done;
              fifo_ctrl.pop = done;
              oidx_d        = IDX_W'(head_ent[ENT_W-1:GEN_BITS]);
              ogen_d        = GEN_W'(new_gen);
            end else if (32'(mark_q) >= SLOT_COUNT) begin
              status_d = STATUS_FULL;
            end else begin
              slot_waddr = mark_q[SIDX_W-1:0];
              slot_wr    = {1'b1, {GEN_BITS{1'b0}}};
              slot_we    = done;
              mark_d     = done ? mark_q + 1'b1 : mark_q;
              oidx_d     = IDX_W'(mark_q[SIDX_W-1:0]);
            end
          end
          MODE_REMOVE: begin
            if (hit) begin
              alive_d        = 1'b1;
              slot_we        = done;
              fifo_ctrl.push = done;
            end else begin
              status_d = STATUS_DEAD;
            end
          end
          default: begin
            alive_d = hit;
          end
        endcase
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mark_q  <= mark_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mode_q <= mode_i;
      idx_q  <= handle_index_i;
      gen_q  <= handle_generation_i;
    end
    if (done) begin
      status_q <= status_d;
      oidx_q   <= oidx_d;
      ogen_q   <= ogen_d;
      alive_q  <= alive_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_index_o      = oidx_q;
  assign out_generation_o = ogen_q;
  assign alive_o          = alive_q;

  `GHA_ASSERT(a_accept_then_exec, acc |=> (state_q == ST_EXEC), "accept did not start exec")
  `GHA_ASSERT(a_free_le_mark, 32'(free_cnt) <= 32'(mark_q), "more freed slots than handed out")
  `GHA_ASSERT_IMPL(a_pop_nonempty, fifo_ctrl.pop, free_cnt != '0, "pop from empty free queue")
  `GHA_ASSERT_IMPL(a_full_only_at_mark, done && (status_d == STATUS_FULL),
                   32'(mark_q) == SLOT_COUNT, "full reported with fresh slots left")

endmodule
